@@ design/bcdc_pkg.sv @@
package bcdc_pkg;

    // Input actions
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_INCR = 1'b1;

    // Digit select codes for an increment word
    localparam logic [2:0] SEL_HOUR_TENS   = 3'd0;
    localparam logic [2:0] SEL_HOUR_ONES   = 3'd1;
    localparam logic [2:0] SEL_MINUTE_TENS = 3'd2;
    localparam logic [2:0] SEL_MINUTE_ONES = 3'd3;
    localparam logic [2:0] SEL_SECOND_TENS = 3'd4;
    localparam logic [2:0] SEL_SECOND_ONES = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] REG_TICKS_PER_SECOND = 3'd0;
    localparam logic [2:0] REG_ALARM_HHMM       = 3'd1;
    localparam logic [2:0] REG_RELAY_ONE_ON     = 3'd2;
    localparam logic [2:0] REG_RELAY_ONE_OFF    = 3'd3;
    localparam logic [2:0] REG_RELAY_TWO_ON     = 3'd4;
    localparam logic [2:0] REG_RELAY_TWO_OFF    = 3'd5;

    localparam int PRESCALE_W = 14;
    localparam int HHMM_W     = 12;

    // Reset values of the configuration registers
    localparam logic [PRESCALE_W-1:0] TPS_RESET       = 14'd10000;
    localparam logic [HHMM_W-1:0]     ALARM_RESET     = 12'd10;
    localparam logic [HHMM_W-1:0]     RELAY1_ON_RESET  = 12'd10;
    localparam logic [HHMM_W-1:0]     RELAY1_OFF_RESET = 12'd20;
    localparam logic [HHMM_W-1:0]     RELAY2_ON_RESET  = 12'd20;
    localparam logic [HHMM_W-1:0]     RELAY2_OFF_RESET = 12'd30;

    typedef struct packed {
        logic [1:0] hour_tens;
        logic [3:0] hour_ones;
        logic [2:0] minute_tens;
        logic [3:0] minute_ones;
        logic [2:0] second_tens;
        logic [3:0] second_ones;
        logic       alarm_pin;
        logic       relay_one_pin;
        logic       relay_two_pin;
    } result_t;

endpackage

@@ design/bcdc_time_core.sv @@
module bcdc_time_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_write,
    input  logic [2:0]                   cfg_index,
    input  logic [bcdc_pkg::PRESCALE_W-1:0] cfg_data,
    input  logic                         item_accept,
    input  logic                         action,
    input  logic [2:0]                   digit_select,
    output bcdc_pkg::result_t            res_next
);

    logic [bcdc_pkg::PRESCALE_W-1:0] tps_reg;
    logic [bcdc_pkg::HHMM_W-1:0]     alarm_reg;
    logic [bcdc_pkg::HHMM_W-1:0]     r1_on_reg, r1_off_reg, r2_on_reg, r2_off_reg;

    logic [bcdc_pkg::PRESCALE_W-1:0] prescale_reg, prescale_next, prescale_inc;
    logic [1:0] ht_reg, ht_next;
    logic [3:0] ho_reg, ho_next;
    logic [2:0] mt_reg, mt_next;
    logic [3:0] mo_reg, mo_next;
    logic [2:0] st_reg, st_next;
    logic [3:0] so_reg, so_next;
    logic [1:0] relay_reg, relay_next;
    logic [bcdc_pkg::HHMM_W-1:0] now_hhmm;

    // Pin is low inside the window; equal bounds keep the old level.
    function automatic logic relay_level(input logic [11:0] now, input logic [11:0] on_t,
                                         input logic [11:0] off_t, input logic old);
        logic lvl;
        if (on_t < off_t) begin
            lvl = !(now >= on_t && now < off_t);
        end else if (on_t > off_t) begin
            lvl = !(now >= on_t || now < off_t);
        end else begin
            lvl = old;
        end
        return lvl;
    endfunction

    always_comb begin
        prescale_inc  = prescale_reg + 14'd1;
        prescale_next = prescale_reg;
        ht_next = ht_reg;
        ho_next = ho_reg;
        mt_next = mt_reg;
        mo_next = mo_reg;
        st_next = st_reg;
        so_next = so_reg;
        if (action == bcdc_pkg::ACT_TICK) begin
            if (prescale_inc == tps_reg) begin
                prescale_next = '0;
                so_next = so_reg + 4'd1;
                if (so_next > 4'd9) begin
                    st_next = st_next + 3'd1;
                    so_next = '0;
                end
                if (st_next > 3'd5) begin
                    mo_next = mo_next + 4'd1;
                    st_next = '0;
                end
                if (mo_next > 4'd9) begin
                    mt_next = mt_next + 3'd1;
                    mo_next = '0;
                end
                if (mt_next > 3'd5) begin
                    ho_next = ho_next + 4'd1;
                    mt_next = '0;
                end
                if (ho_next > 4'd9) begin
                    ht_next = ht_next + 2'd1;
                    ho_next = '0;
                end
                // Reaching 24:00:00 rolls over to midnight.
                if (ht_next > 2'd1 && ho_next > 4'd3) begin
                    ht_next = '0;
                    ho_next = '0;
                    mt_next = '0;
                    mo_next = '0;
                    st_next = '0;
                    so_next = '0;
                end
            end else begin
                prescale_next = prescale_inc;
            end
        end else begin
            case (digit_select)
                bcdc_pkg::SEL_HOUR_TENS:   ht_next = ht_reg + 2'd1;
                bcdc_pkg::SEL_HOUR_ONES:   ho_next = ho_reg + 4'd1;
                bcdc_pkg::SEL_MINUTE_TENS: mt_next = mt_reg + 3'd1;
                bcdc_pkg::SEL_MINUTE_ONES: mo_next = mo_reg + 4'd1;
                bcdc_pkg::SEL_SECOND_TENS: st_next = st_reg + 3'd1;
                bcdc_pkg::SEL_SECOND_ONES: so_next = so_reg + 4'd1;
                default: ;
            endcase
            if (so_next > 4'd9) so_next = '0;
            if (st_next > 3'd5) st_next = '0;
            if (mo_next > 4'd9) mo_next = '0;
            if (mt_next > 3'd5) mt_next = '0;
            // The hour ones check sees hour tens before its own wrap.
            if (ho_next > 4'd9 || (ht_next > 2'd1 && ho_next > 4'd3)) ho_next = '0;
            if (ht_next > 2'd2) ht_next = '0;
        end

        now_hhmm = 12'(ht_next) * 12'd1000 + 12'(ho_next) * 12'd100
                 + 12'(mt_next) * 12'd10 + 12'(mo_next);

        relay_next[0] = relay_level(now_hhmm, r1_on_reg, r1_off_reg, relay_reg[0]);
        relay_next[1] = relay_level(now_hhmm, r2_on_reg, r2_off_reg, relay_reg[1]);

        res_next.hour_tens     = ht_next;
        res_next.hour_ones     = ho_next;
        res_next.minute_tens   = mt_next;
        res_next.minute_ones   = mo_next;
        res_next.second_tens   = st_next;
        res_next.second_ones   = so_next;
        res_next.alarm_pin     = (now_hhmm == alarm_reg);
        res_next.relay_one_pin = relay_next[0];
        res_next.relay_two_pin = relay_next[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg    <= bcdc_pkg::TPS_RESET;
            alarm_reg  <= bcdc_pkg::ALARM_RESET;
            r1_on_reg  <= bcdc_pkg::RELAY1_ON_RESET;
            r1_off_reg <= bcdc_pkg::RELAY1_OFF_RESET;
            r2_on_reg  <= bcdc_pkg::RELAY2_ON_RESET;
            r2_off_reg <= bcdc_pkg::RELAY2_OFF_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                bcdc_pkg::REG_TICKS_PER_SECOND: tps_reg    <= cfg_data;
                bcdc_pkg::REG_ALARM_HHMM:       alarm_reg  <= cfg_data[11:0];
                bcdc_pkg::REG_RELAY_ONE_ON:     r1_on_reg  <= cfg_data[11:0];
                bcdc_pkg::REG_RELAY_ONE_OFF:    r1_off_reg <= cfg_data[11:0];
                bcdc_pkg::REG_RELAY_TWO_ON:     r2_on_reg  <= cfg_data[11:0];
                bcdc_pkg::REG_RELAY_TWO_OFF:    r2_off_reg <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_reg <= '0;
            ht_reg       <= '0;
            ho_reg       <= '0;
            mt_reg       <= '0;
            mo_reg       <= '0;
            st_reg       <= '0;
            so_reg       <= '0;
            relay_reg    <= '0;
        end else if (item_accept) begin
            prescale_reg <= prescale_next;
            ht_reg       <= ht_next;
            ho_reg       <= ho_next;
            mt_reg       <= mt_next;
            mo_reg       <= mo_next;
            st_reg       <= st_next;
            so_reg       <= so_next;
            relay_reg    <= relay_next;
        end
    end

    a_hour_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        ht_reg == 2'd2 |-> ho_reg <= 4'd3)
        else $error("hour digits past 23");

    a_second_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        so_reg <= 4'd9 && st_reg <= 3'd5)
        else $error("second digits out of range");

    a_incr_keeps_prescale: assert property (@(posedge aclk) disable iff (!aresetn)
        item_accept && action == bcdc_pkg::ACT_INCR |=> $stable(prescale_reg))
        else $error("increment word moved the prescaler");

endmodule

@@ design/bcd_clock_alarm_relay_timer.sv @@
// The result word for an accepted item is registered in the output slot, or in the skid entry while m_ready holds it.
// One item per cycle while s_ready is high; the clock update is a single registered pass.
// A two-entry output buffer lets s_ready stay high while one result waits on m_ready.
// Reset (aresetn low, synchronous): clock at midnight, prescaler zero, relay pins low,
// registers to their defaults and the output buffer empty.
module bcd_clock_alarm_relay_timer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [13:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [2:0]  s_digit_select,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_hour_tens,
    output logic [3:0]  m_hour_ones,
    output logic [2:0]  m_minute_tens,
    output logic [3:0]  m_minute_ones,
    output logic [2:0]  m_second_tens,
    output logic [3:0]  m_second_ones,
    output logic        m_alarm_pin,
    output logic        m_relay_one_pin,
    output logic        m_relay_two_pin
);

    bcdc_pkg::result_t res_next;
    bcdc_pkg::result_t out_reg, skid_reg;
    logic              out_valid_reg, skid_valid_reg;
    logic              s_accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign s_accept  = s_valid && s_ready;

    bcdc_time_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_accept  (s_accept),
        .action       (s_action),
        .digit_select (s_digit_select),
        .res_next     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= s_accept;
            end
        end else if (s_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // The skid entry is always older than a new word, so it drains first.
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (s_accept) begin
                out_reg <= res_next;
            end
        end else if (s_accept) begin
            skid_reg <= res_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_hour_tens     = out_reg.hour_tens;
    assign m_hour_ones     = out_reg.hour_ones;
    assign m_minute_tens   = out_reg.minute_tens;
    assign m_minute_ones   = out_reg.minute_ones;
    assign m_second_tens   = out_reg.second_tens;
    assign m_second_ones   = out_reg.second_ones;
    assign m_alarm_pin     = out_reg.alarm_pin;
    assign m_relay_one_pin = out_reg.relay_one_pin;
    assign m_relay_two_pin = out_reg.relay_two_pin;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with the output slot empty");

    a_stall_fills_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && out_valid_reg && !m_ready |=> skid_valid_reg)
        else $error("word accepted under stall was not buffered");

    a_accept_gives_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> out_valid_reg)
        else $error("accepted word produced no result");

endmodule

@@ verif/tb_bcd_clock_alarm_relay_timer.sv @@
`timescale 1ns / 1ps

module tb_bcd_clock_alarm_relay_timer;

    localparam logic [2:0] SEL_UNUSED_LO = 3'd6;
    localparam logic [2:0] SEL_UNUSED_HI = 3'd7;
    localparam logic [2:0] REG_UNUSED_LO = 3'd6;
    localparam logic [2:0] REG_UNUSED_HI = 3'd7;
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_WORDS = 650;

    typedef struct packed {
        logic       action;
        logic [2:0] sel;
    } clock_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [13:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_action = 1'b0;
    logic [2:0]  s_digit_select = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_hour_tens;
    logic [3:0]  m_hour_ones;
    logic [2:0]  m_minute_tens;
    logic [3:0]  m_minute_ones;
    logic [2:0]  m_second_tens;
    logic [3:0]  m_second_ones;
    logic        m_alarm_pin;
    logic        m_relay_one_pin;
    logic        m_relay_two_pin;

    bcd_clock_alarm_relay_timer dut (.*);

    // Predicted clock state and the register copies it runs against.
    logic [bcdc_pkg::PRESCALE_W-1:0] tick_count;
    logic [3:0]                      clock_digit [6];
    logic [1:0]                      relay_state;
    logic [bcdc_pkg::PRESCALE_W-1:0] set_tps;
    logic [bcdc_pkg::HHMM_W-1:0]     set_alarm;
    logic [bcdc_pkg::HHMM_W-1:0]     relay_start [2];
    logic [bcdc_pkg::HHMM_W-1:0]     relay_stop [2];

    clock_word_t         pending_words [$];
    bcdc_pkg::result_t   expected_times [$];
    clock_word_t         next_word;
    bcdc_pkg::result_t   want;

    logic word_taken = 1'b0;
    logic idle_on = 1'b1;
    int   feed_gap = 0;
    int   sink_gap = 0;
    int   stall_cycles = 0;
    int   error_count = 0;
    int   words_queued = 0;
    int   words_checked = 0;
    int   reg_writes = 0;
    int   alarm_high = 0;
    int   relay_one_low = 0;
    int   relay_two_low = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic window_pin(int now, int start_hhmm, int stop_hhmm, logic held);
        if (start_hhmm < stop_hhmm) return (now >= start_hhmm && now < stop_hhmm) ? 1'b0 : 1'b1;
        if (start_hhmm > stop_hhmm) return (now >= start_hhmm || now < stop_hhmm) ? 1'b0 : 1'b1;
        return held;
    endfunction

    function automatic bcdc_pkg::result_t clock_step(input logic action, input logic [2:0] sel);
        bcdc_pkg::result_t r;
        int      now;
        if (action == bcdc_pkg::ACT_TICK) begin
            tick_count = tick_count + 1'b1;
            if (tick_count == set_tps) begin
                tick_count = '0;
                clock_digit[5]++;
                if (clock_digit[5] > 9) begin clock_digit[4]++; clock_digit[5] = 0; end
                if (clock_digit[4] > 5) begin clock_digit[3]++; clock_digit[4] = 0; end
                if (clock_digit[3] > 9) begin clock_digit[2]++; clock_digit[3] = 0; end
                if (clock_digit[2] > 5) begin clock_digit[1]++; clock_digit[2] = 0; end
                if (clock_digit[1] > 9) begin clock_digit[0]++; clock_digit[1] = 0; end
                if (clock_digit[0] > 1 && clock_digit[1] > 3) begin
                    for (int i = 0; i < 6; i++) clock_digit[i] = 0;
                end
            end
        end else begin
            if (sel <= bcdc_pkg::SEL_SECOND_ONES) clock_digit[sel]++;
            if (clock_digit[5] > 9) clock_digit[5] = 0;
            if (clock_digit[4] > 5) clock_digit[4] = 0;
            if (clock_digit[3] > 9) clock_digit[3] = 0;
            if (clock_digit[2] > 5) clock_digit[2] = 0;
            if (clock_digit[1] > 9 || (clock_digit[0] > 1 && clock_digit[1] > 3))
                clock_digit[1] = 0;
            if (clock_digit[0] > 2) clock_digit[0] = 0;
        end
        now = clock_digit[0] * 1000 + clock_digit[1] * 100 + clock_digit[2] * 10
            + clock_digit[3];
        relay_state[0] = window_pin(now, relay_start[0], relay_stop[0], relay_state[0]);
        relay_state[1] = window_pin(now, relay_start[1], relay_stop[1], relay_state[1]);
        r.hour_tens     = clock_digit[0][1:0];
        r.hour_ones     = clock_digit[1];
        r.minute_tens   = clock_digit[2][2:0];
        r.minute_ones   = clock_digit[3];
        r.second_tens   = clock_digit[4][2:0];
        r.second_ones   = clock_digit[5];
        r.alarm_pin     = (now == set_alarm);
        r.relay_one_pin = relay_state[0];
        r.relay_two_pin = relay_state[1];
        return r;
    endfunction

    function automatic void check_field(string name, int want_v, int got_v);
        if (want_v != got_v) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
        end
    endfunction

    function automatic int minutes_to_hhmm(int total_min);
        int m;
        m = total_min % 1440;
        return (m / 60) * 100 + m % 60;
    endfunction

    // Window edges mostly land a few minutes around the time the scenario starts at.
    function automatic int pick_edge(int base_min);
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 4095);
            1: return $urandom_range(0, 2359);
            default: return minutes_to_hhmm(base_min + 1438 + $urandom_range(0, 6));
        endcase
    endfunction

    function automatic logic [13:0] cfg_word(int hhmm);
        return {2'($urandom_range(0, 3)), 12'(hhmm)};
    endfunction

    // Input side: drive at the falling edge, hold the word until it is taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || word_taken) begin
            if (feed_gap > 0) begin
                feed_gap = feed_gap - 1;
                s_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                feed_gap = $urandom_range(0, 17);
                s_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                next_word = pending_words.pop_front();
                s_valid <= 1'b1;
                s_action <= next_word.action;
                s_digit_select <= next_word.sel;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (sink_gap > 0) begin
            sink_gap = sink_gap - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            sink_gap = $urandom_range(0, 17);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        word_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            expected_times.push_back(clock_step(s_action, s_digit_select));
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_times.size() == 0) begin
                error_count++;
                $display("%0t: result word with none expected, expected nothing, actual %0d",
                         $time, {m_hour_tens, m_hour_ones, m_minute_tens, m_minute_ones});
            end else begin
                want = expected_times.pop_front();
                check_field("hour_tens", want.hour_tens, m_hour_tens);
                check_field("hour_ones", want.hour_ones, m_hour_ones);
                check_field("minute_tens", want.minute_tens, m_minute_tens);
                check_field("minute_ones", want.minute_ones, m_minute_ones);
                check_field("second_tens", want.second_tens, m_second_tens);
                check_field("second_ones", want.second_ones, m_second_ones);
                check_field("alarm_pin", want.alarm_pin, m_alarm_pin);
                check_field("relay_one_pin", want.relay_one_pin, m_relay_one_pin);
                check_field("relay_two_pin", want.relay_two_pin, m_relay_two_pin);
                words_checked++;
                alarm_high += m_alarm_pin;
                relay_one_low += !m_relay_one_pin;
                relay_two_low += !m_relay_two_pin;
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_word(input logic action, input logic [2:0] sel);
        pending_words.push_back('{action, sel});
        words_queued++;
    endtask

    task automatic queue_ticks(input int count);
        repeat (count) queue_word(bcdc_pkg::ACT_TICK, 3'($urandom_range(0, 7)));
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || s_valid || expected_times.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [13:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            bcdc_pkg::REG_TICKS_PER_SECOND: set_tps = data;
            bcdc_pkg::REG_ALARM_HHMM:       set_alarm = data[11:0];
            bcdc_pkg::REG_RELAY_ONE_ON:     relay_start[0] = data[11:0];
            bcdc_pkg::REG_RELAY_ONE_OFF:    relay_stop[0] = data[11:0];
            bcdc_pkg::REG_RELAY_TWO_ON:     relay_start[1] = data[11:0];
            bcdc_pkg::REG_RELAY_TWO_OFF:    relay_stop[1] = data[11:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Bumps one digit at a time, reading the settled time before each digit since
    // an hour tens bump can clear hour ones.
    task automatic set_time(input int hh, input int mm, input int ss);
        int want_digit [6];
        int modulus;
        want_digit = '{hh / 10, hh % 10, mm / 10, mm % 10, ss / 10, ss % 10};
        for (int d = 0; d < 6; d++) begin
            drain();
            case (d)
                0: modulus = 3;
                1: modulus = (clock_digit[0] == 2) ? 4 : 10;
                2, 4: modulus = 6;
                default: modulus = 10;
            endcase
            repeat ((want_digit[d] - clock_digit[d] + modulus) % modulus)
                queue_word(bcdc_pkg::ACT_INCR, 3'(d));
        end
    endtask

    task automatic run_scenario();
        int hh;
        int mm;
        int ss;
        int base_min;
        int tps;
        int edge_a;
        int edge_b;
        hh = $urandom_range(0, 23);
        mm = $urandom_range(0, 59);
        ss = $urandom_range(45, 59);
        if ($urandom_range(0, 3) == 0) begin
            hh = 23;
            mm = $urandom_range(58, 59);
        end
        base_min = hh * 60 + mm;
        drain();
        // Keep the rate above the running count so the clock moves right away.
        tps = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 6) : 1;
        if (tps <= tick_count) tps = tick_count + 1;
        write_reg(bcdc_pkg::REG_TICKS_PER_SECOND, 14'(tps));
        write_reg(bcdc_pkg::REG_ALARM_HHMM, cfg_word(($urandom_range(0, 7) == 0) ?
                  $urandom_range(2360, 4095) : minutes_to_hhmm(base_min + $urandom_range(0, 3))));
        edge_a = pick_edge(base_min);
        edge_b = ($urandom_range(0, 5) == 0) ? edge_a : pick_edge(base_min);
        write_reg(bcdc_pkg::REG_RELAY_ONE_ON, cfg_word(edge_a));
        write_reg(bcdc_pkg::REG_RELAY_ONE_OFF, cfg_word(edge_b));
        edge_a = pick_edge(base_min);
        edge_b = ($urandom_range(0, 5) == 0) ? edge_a : pick_edge(base_min);
        write_reg(bcdc_pkg::REG_RELAY_TWO_ON, cfg_word(edge_a));
        write_reg(bcdc_pkg::REG_RELAY_TWO_OFF, cfg_word(edge_b));
        set_time(hh, mm, ss);
        repeat ($urandom_range(40, 160))
            queue_word(($urandom_range(0, 9) < 2) ? bcdc_pkg::ACT_INCR : bcdc_pkg::ACT_TICK,
                       3'($urandom_range(0, 7)));
    endtask

    initial begin
        int random_start;
        tick_count = '0;
        for (int i = 0; i < 6; i++) clock_digit[i] = 0;
        relay_state = '0;
        set_tps = bcdc_pkg::TPS_RESET;
        set_alarm = bcdc_pkg::ALARM_RESET;
        relay_start[0] = bcdc_pkg::RELAY1_ON_RESET;
        relay_stop[0] = bcdc_pkg::RELAY1_OFF_RESET;
        relay_start[1] = bcdc_pkg::RELAY2_ON_RESET;
        relay_stop[1] = bcdc_pkg::RELAY2_OFF_RESET;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // Default settings: alarm at 00:10, relay one 00:10-00:20, relay two 00:20-00:30.
        queue_word(bcdc_pkg::ACT_INCR, SEL_UNUSED_LO);
        queue_word(bcdc_pkg::ACT_INCR, SEL_UNUSED_HI);
        queue_word(bcdc_pkg::ACT_INCR, bcdc_pkg::SEL_MINUTE_TENS);
        queue_word(bcdc_pkg::ACT_INCR, bcdc_pkg::SEL_MINUTE_TENS);
        repeat (3) queue_word(bcdc_pkg::ACT_INCR, bcdc_pkg::SEL_HOUR_TENS);
        queue_word(bcdc_pkg::ACT_INCR, bcdc_pkg::SEL_HOUR_ONES);
        queue_word(bcdc_pkg::ACT_INCR, bcdc_pkg::SEL_MINUTE_ONES);
        queue_word(bcdc_pkg::ACT_INCR, bcdc_pkg::SEL_SECOND_TENS);
        queue_word(bcdc_pkg::ACT_INCR, bcdc_pkg::SEL_SECOND_ONES);
        drain();

        // One second per tick, alarm at midnight, relay one window across midnight,
        // relay two with equal edges so it holds its level.
        write_reg(bcdc_pkg::REG_TICKS_PER_SECOND, 14'd1);
        write_reg(bcdc_pkg::REG_ALARM_HHMM, 14'h3000);
        write_reg(bcdc_pkg::REG_RELAY_ONE_ON, 14'd2359);
        write_reg(bcdc_pkg::REG_RELAY_ONE_OFF, 14'd1);
        write_reg(bcdc_pkg::REG_RELAY_TWO_ON, 14'h0FFF);
        write_reg(bcdc_pkg::REG_RELAY_TWO_OFF, 14'h0FFF);
        write_reg(REG_UNUSED_LO, 14'h3FFF);
        write_reg(REG_UNUSED_HI, 14'h2AAA);
        set_time(23, 59, 58);
        queue_ticks(4);
        drain();

        // Slowest rate, then a zero rate set below the running count, then a
        // nonzero rate below it: neither may move the clock before the count wraps.
        write_reg(bcdc_pkg::REG_TICKS_PER_SECOND, 14'h3FFF);
        queue_ticks(150);
        drain();
        write_reg(bcdc_pkg::REG_TICKS_PER_SECOND, 14'd0);
        queue_ticks(50);
        drain();
        write_reg(bcdc_pkg::REG_TICKS_PER_SECOND, 14'd100);
        queue_ticks(50);

        random_start = words_queued;
        while (words_queued - random_start < RANDOM_WORDS) begin
            if (words_queued - random_start > RANDOM_WORDS - 250) idle_on = 1'b0;
            run_scenario();
        end
        drain();

        $display("Checked %0d result words across %0d register writes.",
                 words_checked, reg_writes);
        $display("Alarm pin high on %0d words; relay one low on %0d, relay two low on %0d.",
                 alarm_high, relay_one_low, relay_two_low);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
